>>> hdl/ljpf_pkg.sv
// Shared types and constants for the Lennard-Jones pair force block.
// No dependencies; used by ljpf_mul and by lennard_jones_pair_forces.
package ljpf_pkg;

  localparam int MAX_ATOMS_DEF = 64;
  localparam int POS_W         = 32;
  localparam int FRC_W         = 48;
  localparam int ENG_W         = 64;
  localparam int COEF_W        = 63;
  localparam int BOX_W         = 31;
  localparam int IDX_W         = 6;
  localparam int CFG_IDX_W     = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_TWELVE,
    REG_COEF_SIX,
    REG_CUTOFF_SQ,
    REG_BOX_LENGTH
  } cfg_reg_t;

  // right shift applied after a 64x64 product
  typedef enum logic [1:0] {
    SH_NONE,
    SH_16,
    SH_32
  } shift_t;

  // one request to the shared multiplier
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    shift_t      mode;
    logic [63:0] lim;
  } mul_req_t;

  // pair arithmetic steps that go through the multiplier
  typedef enum logic [2:0] {
    OP_SQ,
    OP_RR,
    OP_R6,
    OP_A,
    OP_A2,
    OP_B,
    OP_FM,
    OP_F
  } op_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_CLEAR,
    ST_RDI,
    ST_RDJ,
    ST_LATJ,
    ST_FOLD_GO,
    ST_FOLD_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_CUT,
    ST_DIV_WAIT,
    ST_ENERGY,
    ST_FRD,
    ST_FWR_I,
    ST_FWR_J,
    ST_NEXT,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

endpackage

>>> hdl/ljpf_mul.sv
// Sequential 64x64 multiplier with selectable right shift and saturation.
// One 32x32 partial product a cycle; depends on ljpf_pkg.
module ljpf_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ljpf_pkg::mul_req_t req,
  output logic              done,
  output logic [63:0]       y
);

  ljpf_pkg::mul_req_t r;
  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  prod;
  logic [1:0]   psel;
  logic         pv;
  logic [127:0] acc;
  logic [127:0] pshift;
  logic [127:0] shifted;
  logic [31:0]  opa;
  logic [31:0]  opb;
  logic [63:0]  sat;

  // pick the halves for this partial product
  always_comb begin
    opa = cnt[1] ? r.a[63:32] : r.a[31:0];
    opb = cnt[0] ? r.b[63:32] : r.b[31:0];
  end

  // place the registered partial product
  always_comb begin
    unique case (psel)
      2'd0:    pshift = {64'd0, prod};
      2'd3:    pshift = {prod, 64'd0};
      default: pshift = {32'd0, prod, 32'd0};
    endcase
  end

  // shift and clamp the full product
  always_comb begin
    unique case (r.mode)
      ljpf_pkg::SH_16: shifted = acc >> 16;
      ljpf_pkg::SH_32: shifted = acc >> 32;
      default:         shifted = acc;
    endcase
    if (shifted[127:64] != 64'd0) begin
      sat = r.lim;
    end else if (shifted[63:0] > r.lim) begin
      sat = r.lim;
    end else begin
      sat = shifted[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pv   <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
        pv   <= 1'b0;
        acc  <= 128'd0;
        r    <= req;
      end else if (busy) begin
        if (cnt < 3'd4) begin
          prod <= opa * opb;
          psel <= cnt[1:0];
          pv   <= 1'b1;
        end else begin
          pv <= 1'b0;
        end
        if (pv) begin
          acc <= acc + pshift;
        end
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          y    <= sat;
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> hdl/ljpf_div.sv
// Restoring divider for the inverse square distance, all-ones / den.
// One quotient bit a cycle; depends on nothing else.
module ljpf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] q
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] rden;
  logic [63:0] rem;
  logic [64:0] trial;
  logic [64:0] diff;

  // numerator is all ones, so a one shifts in every step
  always_comb begin
    trial = {rem, 1'b1};
    diff  = trial - {1'b0, rden};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= 64'd0;
        rden <= den;
      end else if (busy) begin
        if (!diff[64]) begin
          rem <= diff[63:0];
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= trial[63:0];
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/ljpf_rem.sv
// Minimum-image fold of one displacement: remainder by the box edge,
// one bit a cycle, then fold into plus or minus half a box; no deps.
module ljpf_rem (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] d,
  input  logic [30:0]        len,
  output logic               done,
  output logic signed [32:0] r
);

  logic        busy;
  logic [5:0]  cnt;
  logic        neg;
  logic [31:0] mag;
  logic [30:0] rem;
  logic [30:0] rlen;
  logic [31:0] trial;
  logic [32:0] diff;
  logic [30:0] pos;
  logic [32:0] folded;

  // one restoring step
  always_comb begin
    trial = {rem, mag[31]};
    diff  = {1'b0, trial} - {2'b0, rlen};
  end

  // floor remainder, then fold above half a box
  always_comb begin
    pos = (neg && (rem != 31'd0)) ? (rlen - rem) : rem;
    if (pos > (rlen >> 1)) begin
      folded = {2'b0, pos} - {2'b0, rlen};
    end else begin
      folded = {2'b0, pos};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= 31'd0;
        rlen <= len;
        neg  <= d[32];
        mag  <= d[32] ? 32'(-d) : d[31:0];
      end else if (busy) begin
        if (cnt == 6'd32) begin
          r    <= folded;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          rem <= diff[32] ? trial[30:0] : diff[30:0];
          mag <= {mag[30:0], 1'b0};
          cnt <= cnt + 6'd1;
        end
      end
    end
  end

endmodule

>>> hdl/lennard_jones_pair_forces.sv
// Top level: position and force memories, frame sequencer, pair datapath.
// Uses ljpf_pkg, ljpf_mul, ljpf_div and ljpf_rem.
//
//  channel  dir  beat                      fields (low bit up)
//  s_*      in   one atom position         pos_x, pos_y, pos_z; tlast last_atom
//  m_*      out  one atom force result     atom_index, force_x/y/z, energy; tlast
//  cfg_*    in   register write            cfg_index selects, cfg_data value
//
// Loading accepts one atom per cycle. The last atom starts a clear sweep of the
// n force entries. Each pair then folds its three axes in the 32-step fold unit
// when the box is nonzero, and squares them in the sequential multiplier. A pair
// inside the cutoff also runs the 64-step divider and the remaining products.
// Each result is read from the force store, then loaded into the output register;
// m_tready low holds the sequencer.
// rst clears the sequencer and the atom count; memories have no reset.
module lennard_jones_pair_forces #(
  parameter int MAX_ATOMS = ljpf_pkg::MAX_ATOMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [95:0]                     s_tdata,  // pos_x, pos_y, pos_z
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [215:0]                    m_tdata,  // atom_index, force_x/y/z, energy
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [ljpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ljpf_pkg::COEF_W-1:0]     cfg_data
);

  localparam int IW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW = $clog2(MAX_ATOMS + 1) + 1;
  localparam logic [CW-1:0] MAX_N = CW'(MAX_ATOMS);
  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] M63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] F_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] LIM12 = M63 / 12;
  localparam logic [63:0] LIM6 = M63 / 6;

  // configuration
  logic [62:0] coef_twelve;
  logic [62:0] coef_six;
  logic [62:0] cutoff_sq;
  logic [30:0] box_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_twelve <= 63'd0;
      coef_six    <= 63'd0;
      cutoff_sq   <= 63'd0;
      box_length  <= 31'd0;
    end else if (cfg_we) begin
      unique case (ljpf_pkg::cfg_reg_t'(cfg_index))
        ljpf_pkg::REG_COEF_TWELVE: coef_twelve <= cfg_data;
        ljpf_pkg::REG_COEF_SIX:    coef_six    <= cfg_data;
        ljpf_pkg::REG_CUTOFF_SQ:   cutoff_sq   <= cfg_data;
        ljpf_pkg::REG_BOX_LENGTH:  box_length  <= cfg_data[30:0];
        default:                   coef_six    <= coef_six;
      endcase
    end
  end

  ljpf_pkg::state_t state;
  ljpf_pkg::state_t state_next;
  ljpf_pkg::op_t    op;

  logic [CW-1:0] count;
  logic [IW-1:0] i;
  logic [IW-1:0] j;
  logic [1:0]    k;

  // memories
  logic [95:0]   pos_mem [MAX_ATOMS];
  logic [95:0]   pos_rdata;
  logic [IW-1:0] pos_raddr;
  logic [143:0]  frc_mem [MAX_ATOMS];
  logic [143:0]  frc_rdata;
  logic [IW-1:0] frc_raddr;
  logic          frc_we;
  logic [IW-1:0] frc_waddr;
  logic [143:0]  frc_wdata;

  // pair datapath
  logic signed [31:0] pi [3];
  logic signed [32:0] d [3];
  logic signed [47:0] f [3];
  logic [63:0] rsq;
  logic [63:0] rinv;
  logic [63:0] r6;
  logic [63:0] a;
  logic [63:0] a2;
  logic [63:0] b;
  logic [63:0] fmag;
  logic [63:0] fm;
  logic        fneg;
  logic signed [63:0] energy;

  // units
  logic               mul_start;
  logic               mul_done;
  logic [63:0]        mul_y;
  ljpf_pkg::mul_req_t mul_req;
  logic               div_start;
  logic               div_done;
  logic [63:0]        div_q;
  logic               rem_start;
  logic               rem_done;
  logic signed [32:0] rem_r;

  // counters and handshakes
  logic          in_beat;
  logic          out_free;
  logic          last_sel;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] i_inc2;
  logic [CW-1:0] j_inc;
  logic          in_cut;
  logic [32:0]   dmag;
  logic [64:0]   rsq_sum;
  logic [63:0]   t12;
  logic [63:0]   t6;
  logic signed [63:0] f0;
  logic signed [63:0] e_pair;
  logic signed [64:0] e_sum;
  logic [47:0]   fprod;

  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign i_inc    = CW'(i) + CW'(1);
  assign i_inc2   = CW'(i) + CW'(2);
  assign j_inc    = CW'(j) + CW'(1);
  assign in_cut   = (rsq != 64'd0) && (rsq < {1'b0, cutoff_sq});
  assign last_sel = (i_inc == count);

  // pair arithmetic helpers
  always_comb begin
    dmag    = d[k][32] ? 33'(-d[k]) : d[k];
    rsq_sum = {1'b0, rsq} + {1'b0, mul_y};
    t12     = (a2 > LIM12) ? M63 : ((a2 << 3) + (a2 << 2));
    t6      = (b > LIM6) ? M63 : ((b << 2) + (b << 1));
    f0      = $signed(t12) - $signed(t6);
    e_pair  = $signed(a2) - $signed(b);
    e_sum   = {energy[63], energy} + {e_pair[63], e_pair};
    fprod   = mul_y[47:0];
  end

  function automatic logic [47:0] sat_add48(input logic [47:0] x, input logic [47:0] y);
    logic [48:0] s;
    s = {x[47], x} + {y[47], y};
    if (s[48] != s[47]) begin
      sat_add48 = s[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    end else begin
      sat_add48 = s[47:0];
    end
  endfunction

  // multiplier operand selection
  always_comb begin
    mul_req.mode = ljpf_pkg::SH_32;
    mul_req.lim  = M63;
    mul_req.a    = rinv;
    mul_req.b    = rinv;
    unique case (op)
      ljpf_pkg::OP_SQ: begin
        mul_req.a    = {31'd0, dmag};
        mul_req.b    = {31'd0, dmag};
        mul_req.mode = ljpf_pkg::SH_NONE;
        mul_req.lim  = ONES;
      end
      ljpf_pkg::OP_RR: begin
        mul_req.lim = ONES;
      end
      ljpf_pkg::OP_R6: begin
        mul_req.a   = r6;
        mul_req.lim = ONES;
      end
      ljpf_pkg::OP_A: begin
        mul_req.a = {1'b0, coef_twelve};
        mul_req.b = r6;
      end
      ljpf_pkg::OP_A2: begin
        mul_req.a = a;
        mul_req.b = r6;
      end
      ljpf_pkg::OP_B: begin
        mul_req.a = {1'b0, coef_six};
        mul_req.b = r6;
      end
      ljpf_pkg::OP_FM: begin
        mul_req.a = fmag;
      end
      ljpf_pkg::OP_F: begin
        mul_req.a    = {31'd0, dmag};
        mul_req.b    = fm;
        mul_req.mode = ljpf_pkg::SH_16;
        mul_req.lim  = F_MAX;
      end
      default: mul_req.a = rinv;
    endcase
  end

  ljpf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .req   (mul_req),
    .done  (mul_done),
    .y     (mul_y)
  );

  ljpf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .den   (rsq),
    .done  (div_done),
    .q     (div_q)
  );

  ljpf_rem u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (rem_start),
    .d     (d[k]),
    .len   (box_length),
    .done  (rem_done),
    .r     (rem_r)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ljpf_pkg::ST_LOAD: begin
        if (in_beat && s_tlast) state_next = ljpf_pkg::ST_CLEAR;
      end
      ljpf_pkg::ST_CLEAR: begin
        if (last_sel) begin
          state_next = (count >= CW'(2)) ? ljpf_pkg::ST_RDI : ljpf_pkg::ST_OUT_RD;
        end
      end
      ljpf_pkg::ST_RDI: state_next = ljpf_pkg::ST_RDJ;
      ljpf_pkg::ST_RDJ: state_next = ljpf_pkg::ST_LATJ;
      ljpf_pkg::ST_LATJ: begin
        state_next = (box_length != 31'd0) ? ljpf_pkg::ST_FOLD_GO : ljpf_pkg::ST_MUL_GO;
      end
      ljpf_pkg::ST_FOLD_GO: state_next = ljpf_pkg::ST_FOLD_WAIT;
      ljpf_pkg::ST_FOLD_WAIT: begin
        if (rem_done) begin
          state_next = (k == 2'd2) ? ljpf_pkg::ST_MUL_GO : ljpf_pkg::ST_FOLD_GO;
        end
      end
      ljpf_pkg::ST_MUL_GO: state_next = ljpf_pkg::ST_MUL_WAIT;
      ljpf_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          unique case (op)
            ljpf_pkg::OP_SQ: begin
              state_next = (k == 2'd2) ? ljpf_pkg::ST_CUT : ljpf_pkg::ST_MUL_GO;
            end
            ljpf_pkg::OP_B: state_next = ljpf_pkg::ST_ENERGY;
            ljpf_pkg::OP_F: begin
              state_next = (k == 2'd2) ? ljpf_pkg::ST_FRD : ljpf_pkg::ST_MUL_GO;
            end
            default: state_next = ljpf_pkg::ST_MUL_GO;
          endcase
        end
      end
      ljpf_pkg::ST_CUT: begin
        state_next = in_cut ? ljpf_pkg::ST_DIV_WAIT : ljpf_pkg::ST_NEXT;
      end
      ljpf_pkg::ST_DIV_WAIT: begin
        if (div_done) state_next = ljpf_pkg::ST_MUL_GO;
      end
      ljpf_pkg::ST_ENERGY: state_next = ljpf_pkg::ST_MUL_GO;
      ljpf_pkg::ST_FRD:    state_next = ljpf_pkg::ST_FWR_I;
      ljpf_pkg::ST_FWR_I:  state_next = ljpf_pkg::ST_FWR_J;
      ljpf_pkg::ST_FWR_J:  state_next = ljpf_pkg::ST_NEXT;
      ljpf_pkg::ST_NEXT: begin
        if (j_inc < count || i_inc2 < count) begin
          state_next = ljpf_pkg::ST_RDI;
        end else begin
          state_next = ljpf_pkg::ST_OUT_RD;
        end
      end
      ljpf_pkg::ST_OUT_RD: begin
        if (out_free) state_next = ljpf_pkg::ST_OUT_LD;
      end
      ljpf_pkg::ST_OUT_LD: begin
        state_next = last_sel ? ljpf_pkg::ST_LOAD : ljpf_pkg::ST_OUT_RD;
      end
      default: state_next = ljpf_pkg::ST_LOAD;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = (state == ljpf_pkg::ST_LOAD);
    mul_start = (state == ljpf_pkg::ST_MUL_GO);
    rem_start = (state == ljpf_pkg::ST_FOLD_GO);
    div_start = (state == ljpf_pkg::ST_CUT) && in_cut;
    pos_raddr = (state == ljpf_pkg::ST_RDJ) ? j : i;
    frc_raddr = (state == ljpf_pkg::ST_FWR_I) ? j : i;
    frc_we    = 1'b0;
    frc_waddr = i;
    frc_wdata = 144'd0;
    unique case (state)
      ljpf_pkg::ST_CLEAR: frc_we = 1'b1;
      ljpf_pkg::ST_FWR_I: begin
        frc_we    = 1'b1;
        frc_wdata = {sat_add48(frc_rdata[143:96], f[2]),
                     sat_add48(frc_rdata[95:48], f[1]),
                     sat_add48(frc_rdata[47:0], f[0])};
      end
      ljpf_pkg::ST_FWR_J: begin
        frc_we    = 1'b1;
        frc_waddr = j;
        frc_wdata = {sat_add48(frc_rdata[143:96], -f[2]),
                     sat_add48(frc_rdata[95:48], -f[1]),
                     sat_add48(frc_rdata[47:0], -f[0])};
      end
      default: frc_we = 1'b0;
    endcase
  end

  // position store: write on load, registered read
  always_ff @(posedge clk) begin
    if (in_beat && (count < MAX_N)) begin
      pos_mem[count[IW-1:0]] <= s_tdata;
    end
    pos_rdata <= pos_mem[pos_raddr];
  end

  // force store: read, add and write back
  always_ff @(posedge clk) begin
    if (frc_we) begin
      frc_mem[frc_waddr] <= frc_wdata;
    end
    frc_rdata <= frc_mem[frc_raddr];
  end

  // sequencer state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ljpf_pkg::ST_LOAD;
      count <= '0;
      i     <= '0;
      j     <= '0;
      k     <= 2'd0;
      op    <= ljpf_pkg::OP_SQ;
    end else begin
      state <= state_next;
      unique case (state)
        ljpf_pkg::ST_LOAD: begin
          i <= '0;
          if (in_beat && (count < MAX_N)) count <= count + CW'(1);
        end
        ljpf_pkg::ST_CLEAR: begin
          if (last_sel) begin
            i <= '0;
            j <= IW'(1);
          end else begin
            i <= i + IW'(1);
          end
        end
        ljpf_pkg::ST_LATJ: begin
          k  <= 2'd0;
          op <= ljpf_pkg::OP_SQ;
        end
        ljpf_pkg::ST_FOLD_WAIT: begin
          if (rem_done) k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
        end
        ljpf_pkg::ST_MUL_WAIT: begin
          if (mul_done) begin
            unique case (op)
              ljpf_pkg::OP_SQ: k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
              ljpf_pkg::OP_RR: op <= ljpf_pkg::OP_R6;
              ljpf_pkg::OP_R6: op <= ljpf_pkg::OP_A;
              ljpf_pkg::OP_A:  op <= ljpf_pkg::OP_A2;
              ljpf_pkg::OP_A2: op <= ljpf_pkg::OP_B;
              ljpf_pkg::OP_FM: begin
                op <= ljpf_pkg::OP_F;
                k  <= 2'd0;
              end
              ljpf_pkg::OP_F:  k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
              default:         op <= op;
            endcase
          end
        end
        ljpf_pkg::ST_DIV_WAIT: begin
          if (div_done) op <= ljpf_pkg::OP_RR;
        end
        ljpf_pkg::ST_ENERGY: op <= ljpf_pkg::OP_FM;
        ljpf_pkg::ST_NEXT: begin
          if (j_inc < count) begin
            j <= j + IW'(1);
          end else if (i_inc2 < count) begin
            i <= i + IW'(1);
            j <= i + IW'(2);
          end else begin
            i <= '0;
          end
        end
        ljpf_pkg::ST_OUT_LD: begin
          if (last_sel) begin
            count <= '0;
            i     <= '0;
          end else begin
            i <= i + IW'(1);
          end
        end
        default: k <= k;
      endcase
    end
  end

  // pair datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ljpf_pkg::ST_CLEAR: energy <= 64'sd0;
      ljpf_pkg::ST_RDJ: begin
        pi[0] <= pos_rdata[31:0];
        pi[1] <= pos_rdata[63:32];
        pi[2] <= pos_rdata[95:64];
      end
      ljpf_pkg::ST_LATJ: begin
        d[0] <= 33'(pi[0]) - 33'($signed(pos_rdata[31:0]));
        d[1] <= 33'(pi[1]) - 33'($signed(pos_rdata[63:32]));
        d[2] <= 33'(pi[2]) - 33'($signed(pos_rdata[95:64]));
      end
      ljpf_pkg::ST_FOLD_WAIT: begin
        if (rem_done) d[k] <= rem_r;
      end
      ljpf_pkg::ST_MUL_WAIT: begin
        if (mul_done) begin
          unique case (op)
            ljpf_pkg::OP_SQ: begin
              if (k == 2'd0) rsq <= mul_y;
              else rsq <= rsq_sum[64] ? ONES : rsq_sum[63:0];
            end
            ljpf_pkg::OP_RR: r6 <= mul_y;
            ljpf_pkg::OP_R6: r6 <= mul_y;
            ljpf_pkg::OP_A:  a  <= mul_y;
            ljpf_pkg::OP_A2: a2 <= mul_y;
            ljpf_pkg::OP_B:  b  <= mul_y;
            ljpf_pkg::OP_FM: fm <= mul_y;
            ljpf_pkg::OP_F:  f[k] <= (d[k][32] != fneg) ? -fprod : fprod;
            default:         b  <= b;
          endcase
        end
      end
      ljpf_pkg::ST_DIV_WAIT: begin
        if (div_done) rinv <= div_q;
      end
      ljpf_pkg::ST_ENERGY: begin
        if (e_sum[64] != e_sum[63]) begin
          energy <= e_sum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
          energy <= e_sum[63:0];
        end
        fneg <= f0[63];
        fmag <= f0[63] ? 64'(-f0) : f0;
      end
      default: fneg <= fneg;
    endcase
  end

  // output register: load a result, drop it on a taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ljpf_pkg::ST_OUT_LD) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ljpf_pkg::ST_OUT_LD) begin
      m_tdata <= {2'b00,
                  last_sel ? energy : 64'sd0,
                  frc_rdata[143:96],
                  frc_rdata[95:48],
                  frc_rdata[47:0],
                  ljpf_pkg::IDX_W'(i)};
      m_tlast <= last_sel;
    end
  end

endmodule

>>> verif/testbench.sv
// Testbench for lennard_jones_pair_forces: loads atom frames, predicts per-atom forces
// and total energy in fixed point, and checks every result beat against the prediction.
// Depends on hdl/ljpf_pkg.sv and hdl/lennard_jones_pair_forces.sv.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NATOMS     = 64;
  localparam longint      CYCLE_CAP  = 3000000;
  localparam logic [62:0] C_MAX      = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] U_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] M63        = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint      FRC_MAX    = 64'sh7FFF_FFFF_FFFF;
  localparam longint      FRC_MIN    = -64'sh8000_0000_0000;
  localparam int          NSET       = 5;
  localparam int          KEEP_RESET = -1;

  typedef struct {
    logic [5:0]  idx;
    logic [47:0] fx, fy, fz;
    logic [63:0] energy;
    bit          last;
  } force_beat_t;

  typedef struct {
    int          setting;
    logic [31:0] x, y, z;
    bit          last;
    bit          typed_zero;
  } atom_row_t;

  typedef struct {
    logic [62:0] c12, c6, cut;
    logic [30:0] box;
  } lj_setting_t;

  logic         clk, rst;
  logic         s_tvalid, s_tready, s_tlast;
  logic [95:0]  s_tdata;
  logic         m_tvalid, m_tready, m_tlast;
  logic [215:0] m_tdata;
  logic         cfg_we;
  logic [ljpf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ljpf_pkg::COEF_W-1:0]    cfg_data;

  // predictor state
  logic [62:0] p_c12, p_c6, p_cut;
  logic [30:0] p_box;
  longint      pos_x[NATOMS], pos_y[NATOMS], pos_z[NATOMS];
  longint      frc_x[NATOMS], frc_y[NATOMS], frc_z[NATOMS];
  longint      energy_total;
  int          loaded;

  force_beat_t expected_forces[$];
  lj_setting_t settings[NSET];
  atom_row_t   atom_rows[22];

  int     idle_pct, stall_pct;
  bit     hold_start;
  bit     hold_taken = 1'b0;
  int     hold_left;
  int     errors, beats_checked, atoms_sent, frames_sent;
  longint cycles = 0;

  lennard_jones_pair_forces u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------- fixed-point helpers ----------------
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh,
                                            logic [63:0] lim);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return (p > {64'd0, lim}) ? lim : p[63:0];
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    logic [63:0] u;
    u = v;
    return (v < 0) ? 64'd0 - u : u;
  endfunction

  function automatic longint min_image(longint d);
    longint len, r;
    len = longint'({33'd0, p_box});
    if (len == 0) return d;
    r = d % len;
    if (r < 0) r += len;
    if (r > (len >>> 1)) r -= len;
    return r;
  endfunction

  function automatic longint sat_force_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > FRC_MAX) return FRC_MAX;
    if (s < FRC_MIN) return FRC_MIN;
    return s;
  endfunction

  function automatic longint sat_energy_add(longint a, longint b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_times(logic [63:0] v, logic [63:0] k);
    return (v > M63 / k) ? M63 : v * k;
  endfunction

  function automatic longint force_part(longint d, logic [63:0] fm, bit fneg);
    logic [63:0] p;
    p = mul_shift(magnitude(d), fm, 16, 64'(FRC_MAX));
    return ((d < 0) != fneg) ? -longint'(p) : longint'(p);
  endfunction

  // one pair interaction: add force to atom i, subtract from atom j
  task automatic apply_pair(int i, int j);
    longint dx, dy, dz, f0, fx, fy, fz;
    logic [64:0] rsq;
    logic [63:0] rinv, r6, a, a2, b, fm;
    bit fneg;
    dx = min_image(pos_x[i] - pos_x[j]);
    dy = min_image(pos_y[i] - pos_y[j]);
    dz = min_image(pos_z[i] - pos_z[j]);
    rsq = 65'(magnitude(dx) * magnitude(dx)) + 65'(magnitude(dy) * magnitude(dy));
    if (rsq[64]) rsq = {1'b0, U_MAX};
    rsq = rsq + 65'(magnitude(dz) * magnitude(dz));
    if (rsq[64]) rsq = {1'b0, U_MAX};
    if (rsq == 0 || rsq[63:0] >= {1'b0, p_cut}) return;
    rinv = U_MAX / rsq[63:0];
    r6 = mul_shift(mul_shift(rinv, rinv, 32, U_MAX), rinv, 32, U_MAX);
    a  = mul_shift({1'b0, p_c12}, r6, 32, M63);
    a2 = mul_shift(a, r6, 32, M63);
    b  = mul_shift({1'b0, p_c6}, r6, 32, M63);
    energy_total = sat_energy_add(energy_total, longint'(a2) - longint'(b));
    f0 = longint'(sat_times(a2, 12)) - longint'(sat_times(b, 6));
    fneg = f0 < 0;
    fm = mul_shift(magnitude(f0), rinv, 32, M63);
    fx = force_part(dx, fm, fneg);
    fy = force_part(dy, fm, fneg);
    fz = force_part(dz, fm, fneg);
    frc_x[i] = sat_force_add(frc_x[i], fx);
    frc_y[i] = sat_force_add(frc_y[i], fy);
    frc_z[i] = sat_force_add(frc_z[i], fz);
    frc_x[j] = sat_force_add(frc_x[j], -fx);
    frc_y[j] = sat_force_add(frc_y[j], -fy);
    frc_z[j] = sat_force_add(frc_z[j], -fz);
  endtask

  // store one accepted atom; on the last atom compute the frame and queue its results
  task automatic predict_atom(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last,
                              bit typed_zero);
    force_beat_t e;
    int n;
    if (loaded < NATOMS) begin
      pos_x[loaded] = longint'(signed'(x));
      pos_y[loaded] = longint'(signed'(y));
      pos_z[loaded] = longint'(signed'(z));
      loaded++;
    end
    if (!last) return;
    n = loaded;
    for (int k = 0; k < NATOMS; k++) begin
      frc_x[k] = 0; frc_y[k] = 0; frc_z[k] = 0;
    end
    energy_total = 0;
    if (!typed_zero)
      for (int i = 0; i + 1 < n; i++)
        for (int j = i + 1; j < n; j++) apply_pair(i, j);
    for (int i = 0; i < n; i++) begin
      e.idx    = 6'(i);
      e.last   = (i + 1 == n);
      // typed rows: nothing can act, so every force and the energy are zero
      e.fx     = typed_zero ? 48'd0 : frc_x[i][47:0];
      e.fy     = typed_zero ? 48'd0 : frc_y[i][47:0];
      e.fz     = typed_zero ? 48'd0 : frc_z[i][47:0];
      e.energy = (e.last && !typed_zero) ? energy_total : 64'd0;
      expected_forces.push_back(e);
    end
    loaded = 0;
    frames_sent++;
  endtask

  // ---------------- drivers ----------------
  task automatic send_atom(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last,
                           bit typed_zero);
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_atom(x, y, z, last, typed_zero);
    atoms_sent++;
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // drain: every queued result back, then let the sequencer settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_setting(lj_setting_t s);
    cfg_we <= 1'b1;
    cfg_index <= ljpf_pkg::REG_COEF_TWELVE; cfg_data <= s.c12;      @(posedge clk);
    cfg_index <= ljpf_pkg::REG_COEF_SIX;    cfg_data <= s.c6;       @(posedge clk);
    cfg_index <= ljpf_pkg::REG_CUTOFF_SQ;   cfg_data <= s.cut;      @(posedge clk);
    cfg_index <= ljpf_pkg::REG_BOX_LENGTH;  cfg_data <= 63'(s.box); @(posedge clk);
    cfg_we <= 1'b0;
    p_c12 = s.c12; p_c6 = s.c6; p_cut = s.cut; p_box = s.box;
  endtask

  // random coordinate: mostly near the previous atom, sometimes anywhere
  function automatic logic [31:0] near_coord(logic [31:0] prev);
    if ($urandom_range(99) < 25) return $urandom;
    return prev + 32'($urandom_range(0, 262144)) - 32'd131072;
  endfunction

  task automatic send_frame(int n);
    logic [31:0] x, y, z;
    x = $urandom_range(0, 655360); y = $urandom_range(0, 655360); z = $urandom_range(0, 655360);
    for (int k = 0; k < n; k++) begin
      send_atom(x, y, z, k == n - 1, 1'b0);
      x = near_coord(x); y = near_coord(y); z = near_coord(z);
    end
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_start && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 3000;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    force_beat_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_forces.size() == 0) begin
        $error("unexpected result beat, atom_index %0d", m_tdata[5:0]);
        errors++;
      end else begin
        e = expected_forces.pop_front();
        beats_checked++;
        if (m_tdata[5:0] !== e.idx) begin
          $error("atom_index expected %0d got %0d", e.idx, m_tdata[5:0]); errors++;
        end
        if (m_tdata[53:6] !== e.fx) begin
          $error("force_x expected %h got %h", e.fx, m_tdata[53:6]); errors++;
        end
        if (m_tdata[101:54] !== e.fy) begin
          $error("force_y expected %h got %h", e.fy, m_tdata[101:54]); errors++;
        end
        if (m_tdata[149:102] !== e.fz) begin
          $error("force_z expected %h got %h", e.fz, m_tdata[149:102]); errors++;
        end
        if (m_tdata[213:150] !== e.energy) begin
          $error("potential_energy expected %h got %h", e.energy, m_tdata[213:150]);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last_result expected %0d got %0d", e.last, m_tlast); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_CAP) begin
      $display("lennard_jones_pair_forces: mismatch");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    int cur_setting, n;
    lj_setting_t rs;
    clk = 0; rst = 1;
    s_tvalid = 0; s_tdata = '0; s_tlast = 0;
    cfg_we = 0; cfg_index = ljpf_pkg::REG_COEF_TWELVE; cfg_data = '0;
    hold_start = 0;
    idle_pct = 0; stall_pct = 0;
    errors = 0; beats_checked = 0; atoms_sent = 0; frames_sent = 0;
    p_c12 = 0; p_c6 = 0; p_cut = 0; p_box = 0; loaded = 0; energy_total = 0;

    // typical argon-like units, then the extremes
    settings[0] = '{63'd262144, 63'd262144, 63'd26843545600, 31'd655360};
    settings[1] = '{C_MAX, C_MAX, C_MAX, 31'h7FFF_FFFF};
    settings[2] = '{63'd262144, 63'd524288, C_MAX, 31'd0};
    settings[3] = '{63'd0, C_MAX, C_MAX, 31'd196608};
    settings[4] = '{63'd8000000, 63'd3000, 63'd80000000000, 31'd3};

    atom_rows = '{
      // reset configuration: zero cutoff, so no pair ever acts
      '{KEEP_RESET, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1, 1},  // single atom
      '{KEEP_RESET, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1},
      '{KEEP_RESET, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1, 1},
      // coincident atoms are skipped
      '{0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0},
      '{0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 0},
      // pair at one sigma
      '{0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0},
      '{0, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1, 0},
      // pair across the box wall, close only through the periodic image
      '{0, 32'h0009_8000, 32'h0000_0000, 32'h0000_0000, 0, 0},
      '{0, 32'h0000_4000, 32'h0000_0000, 32'h0000_0000, 1, 0},
      // three atoms, one outside the cutoff
      '{0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0},
      '{0, 32'h0001_1EB8, 32'h0000_0000, 32'h0000_0000, 0, 0},
      '{0, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000, 1, 0},
      // maximum coefficients: every stage saturates
      '{1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0},
      '{1, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1, 0},
      '{1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0},
      '{1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0},
      // no folding, full-range displacements
      '{2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0},
      '{2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0},
      '{2, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0},
      '{2, 32'h0001_8000, 32'hFFFF_8000, 32'h0000_0000, 1, 0},
      // zero repulsion, small box
      '{3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0},
      '{3, 32'h0000_C000, 32'h0000_8000, 32'hFFFF_C000, 1, 0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    cur_setting = KEEP_RESET;
    foreach (atom_rows[r]) begin
      if (atom_rows[r].setting != cur_setting) begin
        wait_drained();
        cur_setting = atom_rows[r].setting;
        write_setting(settings[cur_setting]);
      end
      send_atom(atom_rows[r].x, atom_rows[r].y, atom_rows[r].z, atom_rows[r].last,
                atom_rows[r].typed_zero);
    end

    // random frames over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 21 : 0;
      stall_pct = (ph == 2) ? 54 : (ph == 3) ? 21 : 0;
      for (int f = 0; f < 5; f++) begin
        if (f % 2 == 0) begin
          wait_drained();
          if ($urandom_range(3) == 0) begin
            rs.c12 = 63'({$urandom_range(0, 255), $urandom} >> $urandom_range(0, 40));
            rs.c6  = 63'({$urandom_range(0, 255), $urandom} >> $urandom_range(0, 40));
            rs.cut = 63'({$urandom, $urandom} >> $urandom_range(1, 30));
            rs.box = 31'($urandom >> $urandom_range(1, 16));
            write_setting(rs);
          end else begin
            write_setting(settings[$urandom_range(0, NSET - 1)]);
          end
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
        // long receiver hold while the next frame keeps offering atoms
        if (ph == 0 && f == 1) hold_start = 1'b1;
        send_frame(n);
      end
    end

    // full store plus one dropped last atom
    wait_drained();
    idle_pct = 0; stall_pct = 0;
    write_setting(settings[0]);
    send_frame(NATOMS + 1);

    wait_drained();
    repeat (200) @(posedge clk);
    $display("%0d atoms in %0d frames loaded, %0d force beats checked over %0d cycles",
             atoms_sent, frames_sent, beats_checked, cycles);
    if (errors == 0 && expected_forces.size() == 0) begin
      $display("lennard_jones_pair_forces: match");
    end else begin
      $display("lennard_jones_pair_forces: mismatch");
    end
    $finish;
  end

endmodule
